/* design/prpg_pkg.sv */
// Shared types and constants for the pinhole primary ray generator.
// Register map codes, fixed datapath widths and per-ray flag bundle.
// No dependencies.
package prpg_pkg;

  // Configuration port geometry: 64-bit data, one register every 8 bytes
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_PIXEL_SIZE     = 3'd0,
    REG_HORIZONTAL_RES = 3'd1,
    REG_VERTICAL_RES   = 3'd2,
    REG_BASIS_U        = 3'd3,
    REG_BASIS_V        = 3'd4,
    REG_BASIS_W        = 3'd5,
    REG_VIEW_DISTANCE  = 3'd6
  } reg_idx_e;

  // Register reset values
  localparam logic [15:0] PIXEL_SIZE_RST    = 16'd4096;
  localparam logic [12:0] HRES_RST          = 13'd640;
  localparam logic [12:0] VRES_RST          = 13'd480;
  localparam logic [47:0] BASIS_U_RST       = 48'h0000_0000_4000;
  localparam logic [47:0] BASIS_V_RST       = 48'h0000_4000_0000;
  localparam logic [47:0] BASIS_W_RST       = 48'h4000_0000_0000;
  localparam logic [15:0] VIEW_DISTANCE_RST = 16'd2560;

  // Normalization window: largest magnitude ends in [2^NORM_LO, 2^NORM_HI)
  localparam int unsigned NORM_HI    = 30;
  localparam int unsigned NORM_LO    = 29;
  localparam int unsigned NORM_STEPS = 5;

  // Normalized magnitude, sum of squares and length widths
  localparam int unsigned MAG_W      = 30;
  localparam int unsigned SUM_W      = 62;
  localparam int unsigned LEN_W      = 31;
  localparam int unsigned SQRT_STEPS = 31;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } flags_t;

endpackage

/* design/prpg_norm_cell.sv */
// One normalization cell: shifts three magnitudes by a fixed power of two.
// A row of these brings the largest magnitude into the normalization window.
// Depends on prpg_pkg.
module prpg_norm_cell
  import prpg_pkg::*;
#(
  parameter int unsigned MW     = 53,
  parameter int unsigned SHIFT  = 1,
  parameter int unsigned SIDE_W = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [2:0][MW-1:0]     mag_i,
  input  logic [MW-1:0]          m_i,
  input  flags_t                 flags_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [2:0][MW-1:0]     mag_o,
  output logic [MW-1:0]          m_o,
  output flags_t                 flags_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam logic [MW-1:0] R_THR = MW'(1) << (NORM_LO + SHIFT);
  localparam logic [MW-1:0] L_THR = MW'(1) << (NORM_HI - SHIFT);

  logic              vld_q;
  logic [2:0][MW-1:0] mag_d, mag_q;
  logic [MW-1:0]     m_d, m_q;
  flags_t            flags_q;
  logic [SIDE_W-1:0] side_q;

  // Shift right when far above the window, left when far below
  always_comb begin
    if (m_i >= R_THR) begin
      m_d = m_i >> SHIFT;
      for (int j = 0; j < 3; j++) mag_d[j] = mag_i[j] >> SHIFT;
    end else if (m_i < L_THR) begin
      m_d = m_i << SHIFT;
      for (int j = 0; j < 3; j++) mag_d[j] = mag_i[j] << SHIFT;
    end else begin
      m_d   = m_i;
      mag_d = mag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      m_q     <= m_d;
      flags_q <= flags_i;
      side_q  <= side_i;
    end
  end

  assign vld_o   = vld_q;
  assign mag_o   = mag_q;
  assign m_o     = m_q;
  assign flags_o = flags_q;
  assign side_o  = side_q;

endmodule

/* design/prpg_sqrt_cell.sv */
// One square root cell: resolves one root bit of the sum of squares.
// A row of SQRT_STEPS cells gives floor(sqrt(sum)) one bit per stage.
// Depends on prpg_pkg.
module prpg_sqrt_cell
  import prpg_pkg::*;
#(
  parameter int unsigned K      = 0,
  parameter int unsigned SIDE_W = 114
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SUM_W-1:0]  n_i,
  input  logic [SUM_W-1:0]  res_i,
  input  flags_t            flags_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [SUM_W-1:0]  n_o,
  output logic [SUM_W-1:0]  res_o,
  output flags_t            flags_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * K);

  logic              vld_q;
  logic [SUM_W:0]    trial;
  logic [SUM_W-1:0]  n_d, n_q, res_d, res_q;
  flags_t            flags_q;
  logic [SIDE_W-1:0] side_q;

  // Subtract the trial value when it fits and set this root bit
  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    if ({1'b0, n_i} >= trial) begin
      n_d   = n_i - trial[SUM_W-1:0];
      res_d = (res_i >> 1) + BIT;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q     <= n_d;
      res_q   <= res_d;
      flags_q <= flags_i;
      side_q  <= side_i;
    end
  end

  assign vld_o   = vld_q;
  assign n_o     = n_q;
  assign res_o   = res_q;
  assign flags_o = flags_q;
  assign side_o  = side_q;

endmodule

/* design/prpg_div_cell.sv */
// One restoring division cell for three lanes sharing one divisor (the length).
// Brings down one dividend bit and shifts in one quotient bit per stage.
// Depends on prpg_pkg.
module prpg_div_cell
  import prpg_pkg::*;
#(
  parameter int unsigned QW     = 15,
  parameter int unsigned SIDE_W = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [LEN_W-1:0]      len_i,
  input  logic [2:0][LEN_W-1:0] rem_i,
  input  logic [2:0][QW-1:0]    low_i,
  input  flags_t                flags_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  output logic [LEN_W-1:0]      len_o,
  output logic [2:0][LEN_W-1:0] rem_o,
  output logic [2:0][QW-1:0]    low_o,
  output flags_t                flags_o,
  output logic [SIDE_W-1:0]     side_o
);

  logic                  vld_q;
  logic [LEN_W:0]        part;
  logic [LEN_W:0]        diff;
  logic [2:0][LEN_W-1:0] rem_d, rem_q;
  logic [2:0][QW-1:0]    low_d, low_q;
  logic [LEN_W-1:0]      len_q;
  flags_t                flags_q;
  logic [SIDE_W-1:0]     side_q;

  // Bring down the next dividend bit, subtract the divisor when it fits
  always_comb begin
    part = '0;
    diff = '0;
    for (int j = 0; j < 3; j++) begin
      part = {rem_i[j], low_i[j][QW-1]};
      diff = part - {1'b0, len_i};
      if (part >= {1'b0, len_i}) begin
        rem_d[j] = diff[LEN_W-1:0];
        low_d[j] = {low_i[j][QW-2:0], 1'b1};
      end else begin
        rem_d[j] = part[LEN_W-1:0];
        low_d[j] = {low_i[j][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q   <= len_i;
      rem_q   <= rem_d;
      low_q   <= low_d;
      flags_q <= flags_i;
      side_q  <= side_i;
    end
  end

  assign vld_o   = vld_q;
  assign len_o   = len_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;
  assign flags_o = flags_q;
  assign side_o  = side_q;

endmodule

/* design/pinhole_primary_ray_generator_core.sv */
// Pinhole primary ray generator top level: register port, front-end datapath,
// cell rows for normalization, square root and division, output skid stage.
// Depends on prpg_pkg, prpg_norm_cell, prpg_sqrt_cell, prpg_div_cell.
//
// Issues one ray per clock while in_ready_o is high: a new pixel transaction is
// taken every cycle that the pipeline is not held, and each gives one unit
// direction. Its path runs through six front-end stages, five normalization
// cells, the square and sum stages, a row of 31 square root cells (one root bit
// per stage), the dividend setup, a row of DIR_FRAC_BITS + 1 division cells (one
// quotient bit per stage) and the output register.
// in_ready_o drops only when a result waits at the output and a second one
// sits in the skid register. Write the registers only while no ray is in
// flight; the datapath reads them live.
module pinhole_primary_ray_generator_core
  import prpg_pkg::*;
#(
  parameter int unsigned RES_BITS      = 12,
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [RES_BITS-1:0]           row_i,
  input  logic [RES_BITS-1:0]           col_i,
  input  logic [7:0]                    sample_x_i,
  input  logic [7:0]                    sample_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DIR_FRAC_BITS+1:0] dir_x_o,
  output logic signed [DIR_FRAC_BITS+1:0] dir_y_o,
  output logic signed [DIR_FRAC_BITS+1:0] dir_z_o,
  output logic [RES_BITS-1:0]           pixel_row_o,
  output logic [RES_BITS-1:0]           pixel_col_o,
  output logic                          degenerate_o
);

  // Datapath widths
  localparam int unsigned OW     = ((RES_BITS + 8 > 20) ? RES_BITS + 8 : 20) + 1;
  localparam int unsigned XW     = OW + 17;
  localparam int unsigned CW     = OW + 33;
  localparam int unsigned MW     = OW + 32;
  localparam int unsigned TAG_W  = 2 * RES_BITS;
  localparam int unsigned QW     = DIR_FRAC_BITS + 1;
  localparam int unsigned OUT_W  = DIR_FRAC_BITS + 2;
  localparam int unsigned NUM_W  = MAG_W + DIR_FRAC_BITS + 1;
  localparam int unsigned SQS_W  = 3 * MAG_W + TAG_W;
  localparam int unsigned RES_W  = 3 * OUT_W + TAG_W + 1;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << DIR_FRAC_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] pixel_size_q;
  logic [12:0] hres_q;
  logic [12:0] vres_q;
  logic [47:0] basis_u_q;
  logic [47:0] basis_v_q;
  logic [47:0] basis_w_q;
  logic [15:0] view_dist_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[5:3]);

  // Write the addressed register; drop writes beyond the map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_size_q <= PIXEL_SIZE_RST;
      hres_q       <= HRES_RST;
      vres_q       <= VRES_RST;
      basis_u_q    <= BASIS_U_RST;
      basis_v_q    <= BASIS_V_RST;
      basis_w_q    <= BASIS_W_RST;
      view_dist_q  <= VIEW_DISTANCE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PIXEL_SIZE:     pixel_size_q <= pwdata[15:0];
        REG_HORIZONTAL_RES: hres_q       <= pwdata[12:0];
        REG_VERTICAL_RES:   vres_q       <= pwdata[12:0];
        REG_BASIS_U:        basis_u_q    <= pwdata[47:0];
        REG_BASIS_V:        basis_v_q    <= pwdata[47:0];
        REG_BASIS_W:        basis_w_q    <= pwdata[47:0];
        REG_VIEW_DISTANCE:  view_dist_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (cfg_idx)
      REG_PIXEL_SIZE:     prdata = CFG_DATA_W'(pixel_size_q);
      REG_HORIZONTAL_RES: prdata = CFG_DATA_W'(hres_q);
      REG_VERTICAL_RES:   prdata = CFG_DATA_W'(vres_q);
      REG_BASIS_U:        prdata = CFG_DATA_W'(basis_u_q);
      REG_BASIS_V:        prdata = CFG_DATA_W'(basis_v_q);
      REG_BASIS_W:        prdata = CFG_DATA_W'(basis_w_q);
      REG_VIEW_DISTANCE:  prdata = CFG_DATA_W'(view_dist_q);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline advance: hold everything while the skid register is full
  // ---------------------------------------------------------------------
  logic adv;
  logic skid_v_q;

  assign adv        = ~skid_v_q;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------------
  // Front end: offsets, view-plane point, basis products, components
  // ---------------------------------------------------------------------
  logic                 s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic [TAG_W-1:0]     s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q, s5_tag_q, s6_tag_q;
  logic signed [OW-1:0] s1_ox_d, s1_oy_d, s1_ox_q, s1_oy_q;
  logic signed [XW-1:0] s2_x_d, s2_y_d, s2_x_q, s2_y_q;
  logic signed [32:0]   s2_dw_d [3];
  logic signed [32:0]   s2_dw_q [3];
  logic signed [32:0]   s3_dw_q [3];
  logic signed [CW-1:0] s3_px_d [3];
  logic signed [CW-1:0] s3_py_d [3];
  logic signed [CW-1:0] s3_px_q [3];
  logic signed [CW-1:0] s3_py_q [3];
  logic signed [CW-1:0] s4_c_d [3];
  logic signed [CW-1:0] s4_c_q [3];
  logic signed [CW-1:0] c_abs;
  logic [2:0][MW-1:0]   s5_mag_d, s5_mag_q, s6_mag_q;
  logic [2:0]           s5_neg_q;
  logic [MW-1:0]        s6_m_d, s6_m_q;
  flags_t               s6_flags_q;

  // Form the Q.8 offsets from the image center
  assign s1_ox_d = $signed(OW'({col_i, 8'h00}) - OW'({hres_q, 7'h00}) + OW'(sample_x_i));
  assign s1_oy_d = $signed(OW'({row_i, 8'h00}) - OW'({vres_q, 7'h00}) + OW'(sample_y_i));

  // Scale by the pixel size; form d*w for each axis
  assign s2_x_d = $signed({1'b0, pixel_size_q}) * s1_ox_q;
  assign s2_y_d = $signed({1'b0, pixel_size_q}) * s1_oy_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_dw_d[k] = $signed({1'b0, view_dist_q}) * $signed(basis_w_q[16*k +: 16]);
      s3_px_d[k] = s2_x_q * $signed(basis_u_q[16*k +: 16]);
      s3_py_d[k] = s2_y_q * $signed(basis_v_q[16*k +: 16]);
      s4_c_d[k]  = s3_px_q[k] + s3_py_q[k]
                   - $signed({{(CW-45){s3_dw_q[k][32]}}, s3_dw_q[k], 12'h000});
    end
  end

  // Split components into sign and magnitude
  always_comb begin
    c_abs = '0;
    for (int k = 0; k < 3; k++) begin
      c_abs       = s4_c_q[k][CW-1] ? -s4_c_q[k] : s4_c_q[k];
      s5_mag_d[k] = c_abs[MW-1:0];
    end
  end

  // Pick the largest magnitude
  always_comb begin
    s6_m_d = s5_mag_q[0];
    if (s5_mag_q[1] > s6_m_d) s6_m_d = s5_mag_q[1];
    if (s5_mag_q[2] > s6_m_d) s6_m_d = s5_mag_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ox_q  <= s1_ox_d;
      s1_oy_q  <= s1_oy_d;
      s1_tag_q <= {row_i, col_i};
      s2_x_q   <= s2_x_d;
      s2_y_q   <= s2_y_d;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      s4_tag_q <= s3_tag_q;
      s5_tag_q <= s4_tag_q;
      s6_tag_q <= s5_tag_q;
      for (int k = 0; k < 3; k++) begin
        s2_dw_q[k]  <= s2_dw_d[k];
        s3_dw_q[k]  <= s2_dw_q[k];
        s3_px_q[k]  <= s3_px_d[k];
        s3_py_q[k]  <= s3_py_d[k];
        s4_c_q[k]   <= s4_c_d[k];
        s5_neg_q[k] <= s4_c_q[k][CW-1];
      end
      s5_mag_q         <= s5_mag_d;
      s6_mag_q         <= s5_mag_q;
      s6_m_q           <= s6_m_d;
      s6_flags_q.neg   <= s5_neg_q;
      s6_flags_q.degen <= (s6_m_d == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Normalization row: shifts of 16, 8, 4, 2, 1
  // ---------------------------------------------------------------------
  logic               nm_v     [NORM_STEPS+1];
  logic [2:0][MW-1:0] nm_mag   [NORM_STEPS+1];
  logic [MW-1:0]      nm_m     [NORM_STEPS+1];
  flags_t             nm_flags [NORM_STEPS+1];
  logic [TAG_W-1:0]   nm_tag   [NORM_STEPS+1];

  assign nm_v[0]     = s6_v_q;
  assign nm_mag[0]   = s6_mag_q;
  assign nm_m[0]     = s6_m_q;
  assign nm_flags[0] = s6_flags_q;
  assign nm_tag[0]   = s6_tag_q;

  for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
    prpg_norm_cell #(
      .MW     (MW),
      .SHIFT  (1 << (NORM_STEPS - 1 - i)),
      .SIDE_W (TAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (nm_v[i]),
      .mag_i   (nm_mag[i]),
      .m_i     (nm_m[i]),
      .flags_i (nm_flags[i]),
      .side_i  (nm_tag[i]),
      .vld_o   (nm_v[i+1]),
      .mag_o   (nm_mag[i+1]),
      .m_o     (nm_m[i+1]),
      .flags_o (nm_flags[i+1]),
      .side_o  (nm_tag[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Squares and their sum
  // ---------------------------------------------------------------------
  logic                  sq_v_q, sum_v_q;
  logic [2:0][MAG_W-1:0] sq_mag_q, sum_mag_q;
  logic [2*MAG_W-1:0]    sq_q [3];
  logic [SUM_W-1:0]      sum_q;
  flags_t                sq_flags_q, sum_flags_q;
  logic [TAG_W-1:0]      sq_tag_q, sum_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
    end else if (adv) begin
      sq_v_q  <= nm_v[NORM_STEPS];
      sum_v_q <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq_mag_q[k] <= nm_mag[NORM_STEPS][k][MAG_W-1:0];
        sq_q[k]     <= nm_mag[NORM_STEPS][k][MAG_W-1:0] * nm_mag[NORM_STEPS][k][MAG_W-1:0];
      end
      sq_flags_q  <= nm_flags[NORM_STEPS];
      sq_tag_q    <= nm_tag[NORM_STEPS];
      sum_q       <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      sum_mag_q   <= sq_mag_q;
      sum_flags_q <= sq_flags_q;
      sum_tag_q   <= sq_tag_q;
    end
  end

  // ---------------------------------------------------------------------
  // Square root row: one root bit per cell, top bit first
  // ---------------------------------------------------------------------
  logic             sr_v     [SQRT_STEPS+1];
  logic [SUM_W-1:0] sr_n     [SQRT_STEPS+1];
  logic [SUM_W-1:0] sr_res   [SQRT_STEPS+1];
  flags_t           sr_flags [SQRT_STEPS+1];
  logic [SQS_W-1:0] sr_side  [SQRT_STEPS+1];

  assign sr_v[0]     = sum_v_q;
  assign sr_n[0]     = sum_q;
  assign sr_res[0]   = '0;
  assign sr_flags[0] = sum_flags_q;
  assign sr_side[0]  = {sum_mag_q, sum_tag_q};

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    prpg_sqrt_cell #(
      .K      (SQRT_STEPS - 1 - i),
      .SIDE_W (SQS_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (sr_v[i]),
      .n_i     (sr_n[i]),
      .res_i   (sr_res[i]),
      .flags_i (sr_flags[i]),
      .side_i  (sr_side[i]),
      .vld_o   (sr_v[i+1]),
      .n_o     (sr_n[i+1]),
      .res_o   (sr_res[i+1]),
      .flags_o (sr_flags[i+1]),
      .side_o  (sr_side[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Dividend setup: mag * 2^F + len/2, split into partial remainder and tail
  // ---------------------------------------------------------------------
  logic                  pr_v_q;
  logic [LEN_W-1:0]      pr_len_d, pr_len_q;
  logic [2:0][LEN_W-1:0] pr_rem_d, pr_rem_q;
  logic [2:0][QW-1:0]    pr_low_d, pr_low_q;
  logic [2:0][MAG_W-1:0] pr_mag;
  logic [NUM_W-1:0]      num;
  flags_t                pr_flags_q;
  logic [TAG_W-1:0]      pr_tag_q;

  assign pr_len_d = sr_res[SQRT_STEPS][LEN_W-1:0];
  assign pr_mag   = sr_side[SQRT_STEPS][SQS_W-1:TAG_W];

  always_comb begin
    num = '0;
    for (int k = 0; k < 3; k++) begin
      num = NUM_W'({pr_mag[k], {DIR_FRAC_BITS{1'b0}}}) + NUM_W'(pr_len_d >> 1);
      pr_rem_d[k] = LEN_W'(num[NUM_W-1:QW]);
      pr_low_d[k] = num[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (adv) begin
      pr_v_q <= sr_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_len_q   <= pr_len_d;
      pr_rem_q   <= pr_rem_d;
      pr_low_q   <= pr_low_d;
      pr_flags_q <= sr_flags[SQRT_STEPS];
      pr_tag_q   <= sr_side[SQRT_STEPS][TAG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Division row: one quotient bit per cell for all three axes
  // ---------------------------------------------------------------------
  logic                  dv_v     [QW+1];
  logic [LEN_W-1:0]      dv_len   [QW+1];
  logic [2:0][LEN_W-1:0] dv_rem   [QW+1];
  logic [2:0][QW-1:0]    dv_low   [QW+1];
  flags_t                dv_flags [QW+1];
  logic [TAG_W-1:0]      dv_tag   [QW+1];

  assign dv_v[0]     = pr_v_q;
  assign dv_len[0]   = pr_len_q;
  assign dv_rem[0]   = pr_rem_q;
  assign dv_low[0]   = pr_low_q;
  assign dv_flags[0] = pr_flags_q;
  assign dv_tag[0]   = pr_tag_q;

  for (genvar i = 0; i < QW; i++) begin : g_div
    prpg_div_cell #(
      .QW     (QW),
      .SIDE_W (TAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .vld_i   (dv_v[i]),
      .len_i   (dv_len[i]),
      .rem_i   (dv_rem[i]),
      .low_i   (dv_low[i]),
      .flags_i (dv_flags[i]),
      .side_i  (dv_tag[i]),
      .vld_o   (dv_v[i+1]),
      .len_o   (dv_len[i+1]),
      .rem_o   (dv_rem[i+1]),
      .low_o   (dv_low[i+1]),
      .flags_o (dv_flags[i+1]),
      .side_o  (dv_tag[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // Result: saturate, restore sign, zero degenerate rays
  // ---------------------------------------------------------------------
  logic [RES_W-1:0]      p_res;
  logic [2:0][OUT_W-1:0] p_dir;
  logic [QW-1:0]         q_sat;
  flags_t                p_flags;

  assign p_flags = dv_flags[QW];

  always_comb begin
    q_sat = '0;
    for (int k = 0; k < 3; k++) begin
      q_sat = (dv_low[QW][k] > Q_ONE) ? Q_ONE : dv_low[QW][k];
      if (p_flags.degen) begin
        p_dir[k] = '0;
      end else if (p_flags.neg[k]) begin
        p_dir[k] = -{1'b0, q_sat};
      end else begin
        p_dir[k] = {1'b0, q_sat};
      end
    end
    p_res = {p_flags.degen, dv_tag[QW], p_dir};
  end

  // ---------------------------------------------------------------------
  // Output register and skid register
  // ---------------------------------------------------------------------
  logic             out_v_q, out_v_d, skid_v_d;
  logic [RES_W-1:0] out_res_q, out_res_d, skid_res_q, skid_res_d;

  // Drain the skid first; park a new result there when the output stalls
  always_comb begin
    out_v_d    = out_v_q;
    out_res_d  = out_res_q;
    skid_v_d   = skid_v_q;
    skid_res_d = skid_res_q;
    if (skid_v_q) begin
      if (out_ready_i) begin
        out_res_d = skid_res_q;
        skid_v_d  = 1'b0;
      end
    end else if (dv_v[QW]) begin
      if (!out_v_q || out_ready_i) begin
        out_v_d   = 1'b1;
        out_res_d = p_res;
      end else begin
        skid_v_d   = 1'b1;
        skid_res_d = p_res;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o  = out_v_q;
  assign dir_x_o      = $signed(out_res_q[OUT_W-1:0]);
  assign dir_y_o      = $signed(out_res_q[2*OUT_W-1:OUT_W]);
  assign dir_z_o      = $signed(out_res_q[3*OUT_W-1:2*OUT_W]);
  assign pixel_col_o  = out_res_q[3*OUT_W +: RES_BITS];
  assign pixel_row_o  = out_res_q[3*OUT_W+RES_BITS +: RES_BITS];
  assign degenerate_o = out_res_q[RES_W-1];

endmodule

/* design/prpg_checker.sv */
// Port-level checks for the pinhole primary ray generator, bound to the top.
// Depends only on the top level's ports.
// Holds the checker module and its bind statement.
module prpg_checker #(
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [DIR_FRAC_BITS+1:0] dir_x_o,
  input logic signed [DIR_FRAC_BITS+1:0] dir_y_o,
  input logic signed [DIR_FRAC_BITS+1:0] dir_z_o,
  input logic                           degenerate_o
);

  localparam int ONE = 1 << DIR_FRAC_BITS;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dir_x_o)
      && $stable(dir_y_o) && $stable(dir_z_o) && $stable(degenerate_o))
    else $error("result changed while stalled");

  // Zero direction on a degenerate ray
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> dir_x_o == '0 && dir_y_o == '0 && dir_z_o == '0)
    else $error("degenerate ray with nonzero direction");

  // Keep every component within unit magnitude
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(dir_x_o) <= ONE && int'(dir_x_o) >= -ONE
      && int'(dir_y_o) <= ONE && int'(dir_y_o) >= -ONE
      && int'(dir_z_o) <= ONE && int'(dir_z_o) >= -ONE)
    else $error("direction component beyond unit range");

  // Drop input ready only behind a waiting result
  a_ready_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // Drop input ready only after an output stall
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input ready fell without an output stall");

endmodule

bind pinhole_primary_ray_generator_core prpg_checker #(
  .DIR_FRAC_BITS (DIR_FRAC_BITS)
) u_prpg_checker (.*);
